/* rtl/chmm_pkg.sv */
// Shared types and constants for the clamped histogram with min/max tracking.
// Used by the channel interfaces and every module of the block.
package chmm_pkg;

  localparam int NUM_BINS_DEF = 10;
  localparam int DATA_W       = 32;
  localparam int IDX_W        = 6;
  localparam int CFG_IDX_W    = 8;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = CFG_IDX_W'(1);

  localparam logic signed [DATA_W-1:0] RANGE_LOW_RST  = 32'sd0;
  localparam logic signed [DATA_W-1:0] RANGE_HIGH_RST = 32'sd65536;

  // How the front end resolved the bin of a sample
  typedef enum logic [1:0] {
    BIN_DIVIDE,
    BIN_FIRST,
    BIN_LAST
  } bin_kind_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic                     invalid;
    logic                     last;
    bin_kind_t                kind;
    logic [DATA_W-1:0]        offset;  // sample - range_low, valid for BIN_DIVIDE
    logic [DATA_W-1:0]        span;    // range_high - range_low, valid for BIN_DIVIDE
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] range_low;
    logic signed [DATA_W-1:0] range_high;
    logic                     high_wr;
    logic signed [DATA_W-1:0] wr_value;
  } cfg_view_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_RD,
    BK_UPD,
    BK_DRD,
    BK_DOUT
  } back_state_t;

endpackage

/* rtl/chmm_if.sv */
// Valid/ready channel interfaces: sample input, bin result output, register writes.
// Widths come from chmm_pkg.
interface chmm_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [chmm_pkg::DATA_W-1:0] sample;
  logic                             invalid;
  logic                             end_of_set;
  modport source(output valid, sample, invalid, end_of_set, input ready);
  modport sink(input valid, sample, invalid, end_of_set, output ready);
endinterface

interface chmm_out_if;
  logic                               valid;
  logic                               ready;
  logic [chmm_pkg::IDX_W-1:0]         bin_index;
  logic [chmm_pkg::DATA_W-1:0]        bin_count;
  logic signed [chmm_pkg::DATA_W-1:0] seen_min;
  logic signed [chmm_pkg::DATA_W-1:0] seen_max;
  logic                               final_bin;
  modport source(output valid, bin_index, bin_count, seen_min, seen_max, final_bin,
                 input ready);
  modport sink(input valid, bin_index, bin_count, seen_min, seen_max, final_bin,
               output ready);
endinterface

interface chmm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [chmm_pkg::CFG_IDX_W-1:0] index;
  logic [chmm_pkg::DATA_W-1:0]    data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/clamped_histogram_with_min_max.sv */
// Clamped fixed-bin histogram with running min/max: each valid Q16.16 sample
// is sorted into one of NUM_BINS equal bins over range_low..range_high (out-of-range
// samples clamp to the first or last bin, an empty range puts all in bin 0), counts
// saturate, and an end_of_set beat dumps one result beat per bin and clears.
// Back end sequencing per item: an in-range sample goes through the bit-serial divider,
// then a count memory read and update; a clamped one skips the divide; an invalid one
// is dropped in idle. Per bin, a dump reads the count memory, then loads the result register.
// The front end and a two-entry queue keep accepting samples while the back end works.
// Registers: index 0 range_low, index 1 range_high; writes are taken every cycle.
// Depends on chmm_pkg, chmm_if, chmm_front, chmm_fifo, chmm_back.
module clamped_histogram_with_min_max #(
  parameter int NUM_BINS = chmm_pkg::NUM_BINS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  chmm_in_if.sink     in_ch,
  chmm_out_if.source  out_ch,
  chmm_cfg_if.sink    cfg_ch
);

  logic signed [chmm_pkg::DATA_W-1:0] range_low_r, range_high_r;
  chmm_pkg::cfg_view_t cfg;
  logic                cfg_wr;

  logic            push_valid, push_ready;
  chmm_pkg::item_t push_item;
  logic            pop_valid, pop_ready;
  chmm_pkg::item_t pop_item;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;

  assign cfg.range_low  = range_low_r;
  assign cfg.range_high = range_high_r;
  assign cfg.high_wr    = cfg_wr && (cfg_ch.index == chmm_pkg::REG_RANGE_HIGH);
  assign cfg.wr_value   = cfg_ch.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= chmm_pkg::RANGE_LOW_RST;
      range_high_r <= chmm_pkg::RANGE_HIGH_RST;
    end else if (cfg_wr) begin
      case (cfg_ch.index)
        chmm_pkg::REG_RANGE_LOW:  range_low_r  <= cfg_ch.data;
        chmm_pkg::REG_RANGE_HIGH: range_high_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  chmm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  chmm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  chmm_back #(
    .NUM_BINS (NUM_BINS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

/* rtl/chmm_front.sv */
// Front end: accepts sample beats, classifies them against the range into
// first bin, last bin or a bin that needs a divide. Depends on chmm_pkg, chmm_if.
module chmm_front (
  input  logic                clk,
  input  logic                rst_n,
  chmm_in_if.sink             in_ch,
  input  chmm_pkg::cfg_view_t cfg,
  output logic                push_valid,
  output chmm_pkg::item_t     push_item,
  input  logic                push_ready
);

  logic            st_valid_r, st_valid_nxt;
  chmm_pkg::item_t st_item_r, st_item_nxt;
  logic            accept;

  assign in_ch.ready = !st_valid_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_valid  = st_valid_r;
  assign push_item   = st_item_r;

  always_comb begin
    st_item_nxt.sample  = in_ch.sample;
    st_item_nxt.invalid = in_ch.invalid;
    st_item_nxt.last    = in_ch.end_of_set;
    // Low 32 bits of the differences are exact whenever a divide is needed
    st_item_nxt.offset  = chmm_pkg::DATA_W'(in_ch.sample - cfg.range_low);
    st_item_nxt.span    = chmm_pkg::DATA_W'(cfg.range_high - cfg.range_low);
    if (cfg.range_high <= cfg.range_low || in_ch.sample < cfg.range_low) begin
      st_item_nxt.kind = chmm_pkg::BIN_FIRST;
    end else if (in_ch.sample >= cfg.range_high) begin
      st_item_nxt.kind = chmm_pkg::BIN_LAST;
    end else begin
      st_item_nxt.kind = chmm_pkg::BIN_DIVIDE;
    end
  end

  always_comb begin
    if (accept) begin
      st_valid_nxt = 1'b1;
    end else if (push_ready) begin
      st_valid_nxt = 1'b0;
    end else begin
      st_valid_nxt = st_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= st_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_item_r <= st_item_nxt;
    end
  end

endmodule

/* rtl/chmm_fifo.sv */
// Short queue of classified items between the front end and the back end.
// Depends on chmm_pkg.
module chmm_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  chmm_pkg::item_t push_item,
  output logic            push_ready,
  output logic            pop_valid,
  output chmm_pkg::item_t pop_item,
  input  logic            pop_ready
);

  localparam int DEPTH = chmm_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  chmm_pkg::item_t  mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = cnt_r != CW'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/chmm_back.sv */
// Back end: divides for the bin index, updates the count memory and min/max,
// and streams the per-bin dump. Depends on chmm_pkg, chmm_if.
module chmm_back #(
  parameter int NUM_BINS = chmm_pkg::NUM_BINS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  chmm_pkg::cfg_view_t cfg,
  input  logic                pop_valid,
  input  chmm_pkg::item_t     pop_item,
  output logic                pop_ready,
  chmm_out_if.source          out_ch
);

  localparam int DW   = chmm_pkg::DATA_W;
  localparam int QW   = $clog2(NUM_BINS);
  localparam int SW   = $clog2(QW) + 1;
  localparam int NUMW = DW + QW;
  localparam logic [NUMW-1:0] NB_N     = NUMW'(NUM_BINS);
  localparam logic [QW-1:0]   LAST_BIN = QW'(NUM_BINS - 1);

  chmm_pkg::back_state_t state_r, state_nxt;
  chmm_pkg::item_t       item_r;

  logic [QW-1:0]   bin_r;
  logic [SW-1:0]   step_r;
  logic [NUMW-1:0] rem_r, dvs_r;
  logic            ge;

  logic [DW-1:0]       cnt_mem_r [NUM_BINS];
  logic [NUM_BINS-1:0] cnt_vld_r;
  logic [DW-1:0]       rd_data_r;
  logic                rd_vld_r;
  logic                rd_en;
  logic [QW-1:0]       rd_addr;
  logic                wr_en;
  logic [DW-1:0]       cnt_base, cnt_inc;

  logic signed [DW-1:0] run_min_r, run_max_r;
  logic                 set_open_r;
  logic [QW-1:0]        dump_idx_r;
  logic                 out_load, dump_last, pop;

  logic                          out_valid_r;
  logic [chmm_pkg::IDX_W-1:0]    out_idx_r;
  logic [DW-1:0]                 out_count_r;
  logic signed [DW-1:0]          out_min_r, out_max_r;
  logic                          out_final_r;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.bin_index = out_idx_r;
  assign out_ch.bin_count = out_count_r;
  assign out_ch.seen_min  = out_min_r;
  assign out_ch.seen_max  = out_max_r;
  assign out_ch.final_bin = out_final_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      chmm_pkg::BK_IDLE: begin
        if (pop_valid) begin
          if (pop_item.invalid) begin
            state_nxt = pop_item.last ? chmm_pkg::BK_DRD : chmm_pkg::BK_IDLE;
          end else if (pop_item.kind == chmm_pkg::BIN_DIVIDE) begin
            state_nxt = chmm_pkg::BK_MUL;
          end else begin
            state_nxt = chmm_pkg::BK_RD;
          end
        end
      end
      chmm_pkg::BK_MUL:  state_nxt = chmm_pkg::BK_DIV;
      chmm_pkg::BK_DIV: begin
        if (step_r == '0) begin
          state_nxt = chmm_pkg::BK_RD;
        end
      end
      chmm_pkg::BK_RD:   state_nxt = chmm_pkg::BK_UPD;
      chmm_pkg::BK_UPD:  state_nxt = item_r.last ? chmm_pkg::BK_DRD : chmm_pkg::BK_IDLE;
      chmm_pkg::BK_DRD:  state_nxt = chmm_pkg::BK_DOUT;
      chmm_pkg::BK_DOUT: begin
        if (out_load) begin
          state_nxt = dump_last ? chmm_pkg::BK_IDLE : chmm_pkg::BK_DRD;
        end
      end
      default:           state_nxt = chmm_pkg::BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop_ready = state_r == chmm_pkg::BK_IDLE;
    rd_en     = (state_r == chmm_pkg::BK_RD) || (state_r == chmm_pkg::BK_DRD);
    rd_addr   = (state_r == chmm_pkg::BK_RD) ? bin_r : dump_idx_r;
    wr_en     = state_r == chmm_pkg::BK_UPD;
    out_load  = (state_r == chmm_pkg::BK_DOUT) && (!out_valid_r || out_ch.ready);
  end

  assign pop       = pop_valid && pop_ready;
  assign dump_last = dump_idx_r == LAST_BIN;
  assign ge        = rem_r >= dvs_r;
  assign cnt_base  = rd_vld_r ? rd_data_r : '0;
  assign cnt_inc   = (cnt_base == '1) ? cnt_base : cnt_base + DW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chmm_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Restoring divide of offset*NUM_BINS by span, one quotient bit a cycle;
  // the quotient is known to be below NUM_BINS.
  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= pop_item;
      bin_r  <= (pop_item.kind == chmm_pkg::BIN_LAST) ? LAST_BIN : '0;
    end else if (state_r == chmm_pkg::BK_MUL) begin
      rem_r  <= NUMW'(item_r.offset) * NB_N;
      dvs_r  <= NUMW'(item_r.span) << (QW - 1);
      step_r <= SW'(QW - 1);
      bin_r  <= '0;
    end else if (state_r == chmm_pkg::BK_DIV) begin
      if (ge) begin
        rem_r <= rem_r - dvs_r;
      end
      dvs_r  <= dvs_r >> 1;
      bin_r  <= (bin_r << 1) | QW'(ge);
      step_r <= step_r - SW'(1);
    end
  end

  // Count memory: one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= cnt_mem_r[rd_addr];
    end
    if (wr_en) begin
      cnt_mem_r[bin_r] <= cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      cnt_vld_r  <= '0;
      run_max_r  <= '0;
      run_min_r  <= chmm_pkg::RANGE_HIGH_RST;
      set_open_r <= 1'b0;
      dump_idx_r <= '0;
    end else begin
      if (rd_en) begin
        rd_vld_r <= cnt_vld_r[rd_addr];
      end
      if (wr_en) begin
        cnt_vld_r[bin_r] <= 1'b1;
        set_open_r       <= 1'b1;
        if (item_r.sample > run_max_r) begin
          run_max_r <= item_r.sample;
        end
        if (item_r.sample < run_min_r) begin
          run_min_r <= item_r.sample;
        end
      end
      if (cfg.high_wr && !set_open_r) begin
        run_min_r <= cfg.wr_value;
      end
      if (out_load) begin
        if (dump_last) begin
          dump_idx_r <= '0;
          cnt_vld_r  <= '0;
          run_max_r  <= '0;
          run_min_r  <= cfg.range_high;
          set_open_r <= 1'b0;
        end else begin
          dump_idx_r <= dump_idx_r + QW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r   <= chmm_pkg::IDX_W'(dump_idx_r);
      out_count_r <= cnt_base;
      out_min_r   <= run_min_r;
      out_max_r   <= run_max_r;
      out_final_r <= dump_last;
    end
  end

  a_upd_marks_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == chmm_pkg::BK_UPD) |=> cnt_vld_r[$past(bin_r)])
    else $error("updated bin not marked valid");

  a_out_from_dump: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == chmm_pkg::BK_DOUT))
    else $error("result beat raised outside a dump");

  a_final_is_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_final_r) |-> (out_idx_r == chmm_pkg::IDX_W'(NUM_BINS - 1)))
    else $error("final flag on wrong bin");

  a_dump_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && dump_last) |=> (cnt_vld_r == '0 && !set_open_r && run_max_r == '0))
    else $error("state not cleared after dump");

endmodule

/* test/chmm_hist_checker.sv */
// Checker for the clamped histogram: watches the sample, bin-result and register channels,
// keeps its own copy of bin counts, min/max and range, and compares every bin beat.
// Depends on chmm_pkg and the chmm_if channel interfaces.
module chmm_hist_checker #(
  parameter int NUM_BINS = chmm_pkg::NUM_BINS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  chmm_in_if   in_ch,
  chmm_out_if  out_ch,
  chmm_cfg_if  cfg_ch,
  output int   errors,
  output int   pending,
  output int   samples_taken,
  output int   dumps_seen,
  output int   beats_checked
);
  import chmm_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]         bin_index;
    logic [DATA_W-1:0]        bin_count;
    logic signed [DATA_W-1:0] seen_min;
    logic signed [DATA_W-1:0] seen_max;
    logic                     final_bin;
  } bin_beat_t;

  logic signed [DATA_W-1:0] range_lo, range_hi;
  logic signed [DATA_W-1:0] run_min, run_max;
  logic [DATA_W-1:0]        tally [NUM_BINS];
  bit                       set_open;
  bin_beat_t                dump_q [$];

  // exact integer binning; widened so span and offset never wrap
  function automatic int unsigned bin_for(input logic signed [DATA_W-1:0] x);
    longint span, off, q;
    span = longint'(range_hi) - longint'(range_lo);
    off  = longint'(x) - longint'(range_lo);
    if (span <= 0 || off < 0) return 0;
    q = (off * NUM_BINS) / span;
    if (q >= NUM_BINS) q = NUM_BINS - 1;
    return int'(q);
  endfunction

  task automatic clear_set();
    for (int i = 0; i < NUM_BINS; i++) tally[i] = '0;
    run_max  = '0;
    run_min  = range_hi;
    set_open = 1'b0;
  endtask

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch: %s got %0d want %0d (after %0d good beats)",
             what, got, want, beats_checked);
  endtask

  task automatic take_sample(input logic signed [DATA_W-1:0] x, input logic nan,
                             input logic eos);
    int unsigned b;
    bin_beat_t   r;
    if (!nan) begin
      b = bin_for(x);
      if (x > run_max) run_max = x;
      if (x < run_min) run_min = x;
      if (tally[b] != '1) tally[b] = tally[b] + 1'b1;
      set_open = 1'b1;
      samples_taken++;
    end
    if (eos) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        r.bin_index = IDX_W'(i);
        r.bin_count = tally[i];
        r.seen_min  = run_min;
        r.seen_max  = run_max;
        r.final_bin = (i == NUM_BINS - 1);
        dump_q.insert(dump_q.size(), r);
      end
      clear_set();
      dumps_seen++;
    end
  endtask

  always @(posedge clk) begin
    bin_beat_t want;
    if (!rst_n) begin
      range_lo = RANGE_LOW_RST;
      range_hi = RANGE_HIGH_RST;
      clear_set();
      dump_q.delete();
      errors        = 0;
      samples_taken = 0;
      dumps_seen    = 0;
      beats_checked = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (dump_q.size() == 0) begin
          report("bin beat with nothing expected, index", out_ch.bin_index, -1);
        end else begin
          want = dump_q.pop_front();
          if (out_ch.bin_index !== want.bin_index)
            report("bin_index", out_ch.bin_index, want.bin_index);
          if (out_ch.bin_count !== want.bin_count)
            report("bin_count", out_ch.bin_count, want.bin_count);
          if (out_ch.seen_min !== want.seen_min)
            report("seen_min", longint'(out_ch.seen_min), longint'(want.seen_min));
          if (out_ch.seen_max !== want.seen_max)
            report("seen_max", longint'(out_ch.seen_max), longint'(want.seen_max));
          if (out_ch.final_bin !== want.final_bin)
            report("final_bin", out_ch.final_bin, want.final_bin);
          beats_checked++;
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_RANGE_LOW: range_lo = cfg_ch.data;
          REG_RANGE_HIGH: begin
            range_hi = cfg_ch.data;
            // an open set keeps its minimum
            if (!set_open) run_min = range_hi;
          end
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        take_sample(in_ch.sample, in_ch.invalid, in_ch.end_of_set);
    end
    pending = dump_q.size();
  end

endmodule

/* test/testbench.sv */
// Top of the histogram testbench: clock, reset, sample and register stimulus, result stalls.
// Checking lives in chmm_hist_checker; depends on chmm_pkg, chmm_if and the block itself.
module testbench;
  import chmm_pkg::*;

  localparam int NUM_BINS     = NUM_BINS_DEF;
  localparam int DRAIN_CYCLES = 80;
  localparam int SEG_ITEMS    = 32;
  localparam logic [CFG_IDX_W-1:0]     REG_UNUSED_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0]     REG_UNUSED_HI = '1;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;

  logic clk;
  logic rst_n;
  int   in_gap_pct, out_stall_pct;
  int   n_errors, n_pending, n_samples, n_dumps, n_beats;
  int   n_items, n_writes;
  logic signed [DATA_W-1:0] cur_lo, cur_hi;

  chmm_in_if  in_ch();
  chmm_out_if out_ch();
  chmm_cfg_if cfg_ch();

  clamped_histogram_with_min_max #(.NUM_BINS(NUM_BINS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  chmm_hist_checker #(.NUM_BINS(NUM_BINS)) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .errors        (n_errors),
    .pending       (n_pending),
    .samples_taken (n_samples),
    .dumps_seen    (n_dumps),
    .beats_checked (n_beats)
  );

  always begin
    clk = 1'b0;
    #1 clk = 1'b1;
    #1;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // entered and left just after a falling edge; valid stays up for a following beat
  task automatic push_sample(input logic signed [DATA_W-1:0] s, input logic nan,
                             input logic eos);
    while ($urandom_range(99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.sample     <= s;
    in_ch.invalid    <= nan;
    in_ch.end_of_set <= eos;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    n_items++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
    if (idx == REG_RANGE_LOW) cur_lo = val;
    else if (idx == REG_RANGE_HIGH) cur_hi = val;
    n_writes++;
  endtask

  // all dumps in, then room for samples still in the back end
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] draw_sample();
    longint span;
    span = longint'(cur_hi) - longint'(cur_lo);
    case ($urandom_range(9))
      0, 1: return $urandom();
      2:    return cur_lo - $urandom_range(1, 4096);
      3:    return cur_hi + $urandom_range(0, 4096);
      4:    return $urandom_range(1) ? S32_MIN : S32_MAX;
      5:    return $urandom_range(1) ? cur_lo : cur_hi;
      default: begin
        if (span <= 0) return $urandom();
        return DATA_W'(longint'(cur_lo) + longint'($urandom()) % span);
      end
    endcase
  endfunction

  task automatic run_set(input int len);
    bit all_nan;
    all_nan = ($urandom_range(9) == 0);
    for (int i = 0; i < len; i++)
      push_sample(draw_sample(), all_nan || ($urandom_range(99) < 8), i == len - 1);
  endtask

  task automatic pick_range(input int seg);
    logic signed [DATA_W-1:0] lo, hi;
    case (seg)
      0: begin lo = S32_MIN; hi = S32_MAX; end
      8: begin lo = S32_MAX; hi = S32_MIN; end
      default: begin
        case ($urandom_range(4))
          0: begin lo = RANGE_LOW_RST; hi = RANGE_HIGH_RST; end
          1: begin lo = $urandom(); hi = lo + $urandom_range(1, 40); end
          2: begin lo = $urandom(); hi = $urandom(); end
          3: begin lo = -$urandom_range(1 << 20); hi = $urandom_range(1 << 22); end
          default: begin lo = $urandom(); hi = lo; end
        endcase
      end
    endcase
    if ($urandom_range(1)) begin
      write_reg(REG_RANGE_LOW, lo);
      write_reg(REG_RANGE_HIGH, hi);
    end else begin
      write_reg(REG_RANGE_HIGH, hi);
      write_reg(REG_RANGE_LOW, lo);
    end
  endtask

  initial begin
    int seg_start;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.sample     = '0;
    in_ch.invalid    = 1'b0;
    in_ch.end_of_set = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_RANGE_LOW;
    cfg_ch.data      = '0;
    cur_lo           = RANGE_LOW_RST;
    cur_hi           = RANGE_HIGH_RST;
    in_gap_pct       = 23;
    out_stall_pct    = 70;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty set straight out of reset, NaN carrying the end flag
    push_sample(32'sd0, 1'b1, 1'b1);
    // extremes, clamping and bin edges on the reset range
    push_sample(S32_MIN, 1'b0, 1'b0);
    push_sample(S32_MAX, 1'b0, 1'b0);
    push_sample(32'sd0, 1'b0, 1'b0);
    push_sample(32'sd65535, 1'b0, 1'b0);
    push_sample(32'sd65536, 1'b0, 1'b0);
    push_sample(32'sd6553, 1'b0, 1'b0);
    push_sample(32'sd6554, 1'b0, 1'b0);
    push_sample(S32_MAX, 1'b1, 1'b0);
    push_sample(32'sd32768, 1'b0, 1'b1);
    push_sample(-32'sd1, 1'b0, 1'b1);

    // range moves while a set is open: min must not reload
    push_sample(32'sd100, 1'b0, 1'b0);
    push_sample(32'sd70000, 1'b0, 1'b0);
    quiesce();
    write_reg(REG_RANGE_HIGH, 32'sd655360);
    write_reg(REG_RANGE_LOW, -32'sd655360);
    push_sample(-32'sd655360, 1'b0, 1'b0);
    push_sample(32'sd655359, 1'b0, 1'b0);
    push_sample(-32'sd1, 1'b0, 1'b0);
    push_sample(32'sd0, 1'b1, 1'b1);

    // empty range, then writes to unmapped indexes
    quiesce();
    write_reg(REG_RANGE_HIGH, -32'sd655360);
    push_sample(32'sd12345, 1'b0, 1'b0);
    push_sample(S32_MIN, 1'b0, 1'b1);
    quiesce();
    write_reg(REG_UNUSED_LO, $urandom());
    write_reg(REG_UNUSED_HI, $urandom());
    push_sample(32'sd5, 1'b0, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin in_gap_pct = 23; out_stall_pct = 70; end
        1: begin in_gap_pct = 70; out_stall_pct = 23; end
        default: begin in_gap_pct = 0; out_stall_pct = 0; end
      endcase
      for (int k = 0; k < 3; k++) begin
        quiesce();
        pick_range(phase * 3 + k);
        seg_start = n_items;
        while (n_items - seg_start < SEG_ITEMS)
          run_set(($urandom_range(7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16));
      end
    end

    quiesce();
    $display("drove %0d sample beats (%0d binned) and %0d register writes over three stall mixes",
             n_items, n_samples, n_writes);
    $display("compared %0d bin beats from %0d set dumps, %0d mismatches",
             n_beats, n_dumps, n_errors);
    if (n_errors == 0 && n_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
